FILE: rtl/core/spp_pkg.sv
// spp_pkg: shared constants, types and saturation helpers for the stereo
// ping-pong delay. No dependencies; imported by the line memory, the multiplier and the top level.
package spp_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int STATE_BITS  = 24;
	localparam int STATE_SHIFT = STATE_BITS - SAMPLE_BITS;
	localparam int ADDR_BITS   = 16;
	localparam int LINE_DEPTH  = 1 << ADDR_BITS;
	localparam int CFG_BITS    = 16;
	localparam int IDX_BITS    = 3;
	localparam int MUL_A_BITS  = 28;
	localparam int MUL_B_BITS  = 16;
	localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS + 1;

	localparam logic [CFG_BITS-1:0] UNITY = 16'h8000;

	// register indexes
	localparam logic [IDX_BITS-1:0] REG_DELAY    = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_FEEDBACK = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_PAN      = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_WET      = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_LP_COEF  = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_HP_COEF  = 3'd5;

	// reset values
	localparam logic [CFG_BITS-1:0] RST_DELAY    = 16'd24000;
	localparam logic [CFG_BITS-1:0] RST_FEEDBACK = 16'd16384;
	localparam logic [CFG_BITS-1:0] RST_PAN      = 16'd16384;
	localparam logic [CFG_BITS-1:0] RST_WET      = 16'd32768;
	localparam logic [CFG_BITS-1:0] RST_LP_COEF  = 16'd32768;
	localparam logic [CFG_BITS-1:0] RST_HP_COEF  = 16'd128;

	typedef struct packed {
		logic                         en;
		logic signed [MUL_A_BITS-1:0] a;
		logic [MUL_B_BITS-1:0]        b;
	} mul_req_t;

	typedef struct packed {
		logic                       en;
		logic [ADDR_BITS-1:0]       addr;
		logic [2*SAMPLE_BITS-1:0]   data;
	} line_wr_t;

	function automatic logic signed [STATE_BITS-1:0] sat_state(
		input logic signed [STATE_BITS+2:0] a);
		logic [3:0] hi;
		hi = a[STATE_BITS+2:STATE_BITS-1];
		if (hi == 4'b0000 || hi == 4'b1111) begin
			return a[STATE_BITS-1:0];
		end else if (a[STATE_BITS+2]) begin
			return {1'b1, {(STATE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(STATE_BITS-1){1'b1}}};
		end
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [SAMPLE_BITS+5:0] a);
		logic [6:0] hi;
		hi = a[SAMPLE_BITS+5:SAMPLE_BITS-1];
		if (hi == 7'b0000000 || hi == 7'b1111111) begin
			return a[SAMPLE_BITS-1:0];
		end else if (a[SAMPLE_BITS+5]) begin
			return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	endfunction

endpackage

FILE: rtl/core/spp_line_mem.sv
// spp_line_mem: both delay lines side by side, one write and one read port,
// registered read data. Depends on spp_pkg.
module spp_line_mem (
	input  logic                                clk,
	input  spp_pkg::line_wr_t                   wr,
	input  logic                                rd_en,
	input  logic [spp_pkg::ADDR_BITS-1:0]       rd_addr,
	output logic [2*spp_pkg::SAMPLE_BITS-1:0]   rd_data
);
	import spp_pkg::*;

	logic [2*SAMPLE_BITS-1:0] mem_q [LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/core/spp_mul.sv
// spp_mul: the shared signed-by-unsigned multiplier with a registered product,
// used for every filter, pan, feedback and mix product. Depends on spp_pkg.
module spp_mul (
	input  logic                                  clk,
	input  spp_pkg::mul_req_t                     req,
	output logic signed [spp_pkg::PROD_BITS-1:0]  prod
);
	import spp_pkg::*;

	logic signed [PROD_BITS-1:0] ax;
	logic signed [PROD_BITS-1:0] bx;

	assign ax = PROD_BITS'(req.a);
	assign bx = PROD_BITS'($signed({1'b0, req.b}));

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod <= ax * bx;
		end
	end

endmodule

FILE: rtl/core/stereo_ping_pong_delay.sv
// stereo_ping_pong_delay: top level with sequencer, filter states, config
// registers and output register. Depends on spp_pkg, spp_mul, spp_line_mem.
//
// channel  | signals                      | content
// s_axis   | tvalid tready tdata[31:0]    | left_in [15:0], right_in [31:16]
// m_axis   | tvalid tready tdata[31:0]    | left_out [15:0], right_out [31:16]
// cfg      | cfg_we cfg_index cfg_data    | six 16-bit registers
//
// a pair is accepted in idle, then runs the sequencer steps LPL to DONE, set by
// the ten products that all go through the single multiplier
// the lines are not cleared after reset: a fill count marks never-written
// entries, which read as zero, so the block is ready right after reset
// the finishing step waits while the output register holds an untaken result
module stereo_ping_pong_delay (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [31:0]                     s_axis_tdata,  // left_in, right_in
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [31:0]                     m_axis_tdata,  // left_out, right_out
	input  logic                            cfg_we,
	input  logic [spp_pkg::IDX_BITS-1:0]    cfg_index,
	input  logic [spp_pkg::CFG_BITS-1:0]    cfg_data
);
	import spp_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LPL  = 4'd1;
	localparam logic [3:0] ST_LPR  = 4'd2;
	localparam logic [3:0] ST_HPL  = 4'd3;
	localparam logic [3:0] ST_HPR  = 4'd4;
	localparam logic [3:0] ST_PANL = 4'd5;
	localparam logic [3:0] ST_PANR = 4'd6;
	localparam logic [3:0] ST_FBL  = 4'd7;
	localparam logic [3:0] ST_FBR  = 4'd8;
	localparam logic [3:0] ST_WETL = 4'd9;
	localparam logic [3:0] ST_WETR = 4'd10;
	localparam logic [3:0] ST_DONE = 4'd11;

	logic [3:0] state_q;

	logic [CFG_BITS-1:0] delay_q, fb_q, pan_q, wet_q, lpc_q, hpc_q;
	logic [CFG_BITS-1:0] fb_c, pan_c, wet_c, pan_inv;

	logic [ADDR_BITS-1:0] wp_q;
	logic [ADDR_BITS:0]   fill_q;
	logic [ADDR_BITS-1:0] fill_diff;
	logic                 rd_ok;
	logic                 rd_ok_q;

	logic signed [STATE_BITS-1:0]  fs_q [4];
	logic signed [SAMPLE_BITS-1:0] x_l_q, x_r_q, rd_l_q, rd_r_q;
	logic signed [STATE_BITS-1:0]  lp_l_q, lp_r_q;
	logic signed [STATE_BITS:0]    filt_l_q, filt_r_q;
	logic signed [MUL_A_BITS-1:0]  acc_l_q, acc_r_q;
	logic signed [SAMPLE_BITS-1:0] line_l_q, line_r_q, out_l_q;
	logic                          out_valid_q;
	logic [31:0]                   out_data_q;

	logic                           in_acc;
	logic                           finish;
	mul_req_t                       mreq;
	logic signed [PROD_BITS-1:0]    prod_q;
	line_wr_t                       lwr;
	logic [2*SAMPLE_BITS-1:0]       mem_rdata;

	logic signed [STATE_BITS:0]     d_lpl, d_lpr, d_hpl, d_hpr;
	logic signed [STATE_BITS-1:0]   pole_s;
	logic signed [STATE_BITS:0]     pole_v;
	logic signed [STATE_BITS+1:0]   pole_y;
	logic signed [STATE_BITS+2:0]   pole_yv;
	logic signed [STATE_BITS-1:0]   pole_snew;
	logic signed [STATE_BITS-1:0]   pole_out;
	logic signed [STATE_BITS:0]     hp_filt;
	logic signed [MUL_A_BITS-2:0]   pan_t;
	logic signed [MUL_A_BITS-1:0]   cross_l, cross_r;
	logic signed [PROD_BITS-1:0]    fb_bias;
	logic signed [SAMPLE_BITS-1:0]  fb_line;
	logic signed [SAMPLE_BITS:0]    wet_t;
	logic signed [SAMPLE_BITS+1:0]  wet_sum_x;
	logic signed [SAMPLE_BITS-1:0]  wet_out;
	logic signed [SAMPLE_BITS-1:0]  wet_x;

	assign fb_c    = (fb_q  > UNITY) ? UNITY : fb_q;
	assign pan_c   = (pan_q > UNITY) ? UNITY : pan_q;
	assign wet_c   = (wet_q > UNITY) ? UNITY : wet_q;
	assign pan_inv = UNITY - pan_c;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign finish        = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// entry at the read address was written iff it lies within the fill count
	assign fill_diff = fill_q[ADDR_BITS-1:0] - delay_q;
	assign rd_ok     = fill_q[ADDR_BITS] || ({1'b0, fill_diff} < fill_q);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= RST_DELAY;
			fb_q    <= RST_FEEDBACK;
			pan_q   <= RST_PAN;
			wet_q   <= RST_WET;
			lpc_q   <= RST_LP_COEF;
			hpc_q   <= RST_HP_COEF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DELAY:    delay_q <= cfg_data;
				REG_FEEDBACK: fb_q    <= cfg_data;
				REG_PAN:      pan_q   <= cfg_data;
				REG_WET:      wet_q   <= cfg_data;
				REG_LP_COEF:  lpc_q   <= cfg_data;
				REG_HP_COEF:  hpc_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// filter differences
	assign d_lpl = $signed({x_l_q[SAMPLE_BITS-1], x_l_q, {STATE_SHIFT{1'b0}}})
		- $signed({fs_q[0][STATE_BITS-1], fs_q[0]});
	assign d_lpr = $signed({x_r_q[SAMPLE_BITS-1], x_r_q, {STATE_SHIFT{1'b0}}})
		- $signed({fs_q[2][STATE_BITS-1], fs_q[2]});
	assign d_hpl = (STATE_BITS+1)'(lp_l_q) - (STATE_BITS+1)'(fs_q[1]);
	assign d_hpr = (STATE_BITS+1)'(lp_r_q) - (STATE_BITS+1)'(fs_q[3]);

	// multiplier operands
	always_comb begin
		mreq.en = 1'b0;
		mreq.a  = '0;
		mreq.b  = '0;
		case (state_q)
			ST_LPL: begin
				mreq = '{1'b1, MUL_A_BITS'(d_lpl), lpc_q};
			end
			ST_LPR: begin
				mreq = '{1'b1, MUL_A_BITS'(d_lpr), lpc_q};
			end
			ST_HPL: begin
				mreq = '{1'b1, MUL_A_BITS'(d_hpl), hpc_q};
			end
			ST_HPR: begin
				mreq = '{1'b1, MUL_A_BITS'(d_hpr), hpc_q};
			end
			ST_PANL: begin
				mreq = '{1'b1, MUL_A_BITS'(filt_l_q), pan_c};
			end
			ST_PANR: begin
				mreq = '{1'b1, MUL_A_BITS'(filt_r_q), pan_inv};
			end
			ST_FBL: begin
				mreq = '{1'b1, acc_l_q, fb_c};
			end
			ST_FBR: begin
				mreq = '{1'b1, acc_r_q, fb_c};
			end
			ST_WETL: begin
				mreq = '{1'b1, MUL_A_BITS'(rd_l_q), wet_c};
			end
			ST_WETR: begin
				mreq = '{1'b1, MUL_A_BITS'(rd_r_q), wet_c};
			end
			default: ;
		endcase
	end

	spp_mul u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod_q)
	);

	// one-pole update from the last product
	always_comb begin
		case (state_q)
			ST_LPR:  pole_s = fs_q[0];
			ST_HPL:  pole_s = fs_q[2];
			ST_HPR:  pole_s = fs_q[1];
			default: pole_s = fs_q[3];
		endcase
	end

	assign pole_v    = prod_q[STATE_BITS+16:16];
	assign pole_y    = (STATE_BITS+2)'(pole_v) + (STATE_BITS+2)'(pole_s);
	assign pole_yv   = (STATE_BITS+3)'(pole_y) + (STATE_BITS+3)'(pole_v);
	assign pole_snew = sat_state(pole_yv);
	assign pole_out  = pole_y[STATE_BITS-1:0];

	always_comb begin
		if (state_q == ST_HPR) begin
			hp_filt = (STATE_BITS+1)'(lp_l_q) - (STATE_BITS+1)'(pole_out);
		end else begin
			hp_filt = (STATE_BITS+1)'(lp_r_q) - (STATE_BITS+1)'(pole_out);
		end
	end

	// panned feed plus the cross read
	assign pan_t   = prod_q[MUL_A_BITS+12:14];
	assign cross_l = MUL_A_BITS'($signed({rd_r_q, {STATE_SHIFT{1'b0}}})) + MUL_A_BITS'(pan_t);
	assign cross_r = MUL_A_BITS'($signed({rd_l_q, {STATE_SHIFT{1'b0}}})) + MUL_A_BITS'(pan_t);

	// feedback scaling, rounded toward zero
	assign fb_bias = prod_q[PROD_BITS-1] ?
		PROD_BITS'((1 << (15 + STATE_SHIFT)) - 1) : '0;
	always_comb begin
		logic signed [PROD_BITS-1:0] t;
		t       = prod_q + fb_bias;
		fb_line = sat_sample(t[SAMPLE_BITS+5+15+STATE_SHIFT:15+STATE_SHIFT]);
	end

	// wet mix onto the dry sample
	assign wet_x     = (state_q == ST_WETR) ? x_l_q : x_r_q;
	assign wet_t     = prod_q[SAMPLE_BITS+15:15];
	assign wet_sum_x = (SAMPLE_BITS+2)'(wet_x) + (SAMPLE_BITS+2)'(wet_t);
	assign wet_out   = sat_sample((SAMPLE_BITS+6)'(wet_sum_x));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			rd_ok_q     <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				fs_q[i] <= '0;
			end
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						rd_ok_q <= rd_ok;
						state_q <= ST_LPL;
					end
				end
				ST_LPR: begin
					fs_q[0] <= pole_snew;
					state_q <= ST_HPL;
				end
				ST_HPL: begin
					fs_q[2] <= pole_snew;
					state_q <= ST_HPR;
				end
				ST_HPR: begin
					fs_q[1] <= pole_snew;
					state_q <= ST_PANL;
				end
				ST_PANL: begin
					fs_q[3] <= pole_snew;
					state_q <= ST_PANR;
				end
				ST_DONE: begin
					if (finish) begin
						wp_q    <= wp_q - 1'b1;
						if (!fill_q[ADDR_BITS]) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= state_q + 1'b1;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q <= {wet_out, out_l_q};
		end
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					x_l_q <= s_axis_tdata[SAMPLE_BITS-1:0];
					x_r_q <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
				end
			end
			ST_LPL: begin
				rd_l_q <= rd_ok_q ? mem_rdata[SAMPLE_BITS-1:0] : '0;
				rd_r_q <= rd_ok_q ? mem_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
			end
			ST_LPR:  lp_l_q   <= pole_out;
			ST_HPL:  lp_r_q   <= pole_out;
			ST_HPR:  filt_l_q <= hp_filt;
			ST_PANL: filt_r_q <= hp_filt;
			ST_PANR: acc_l_q  <= cross_l;
			ST_FBL:  acc_r_q  <= cross_r;
			ST_FBR:  line_l_q <= fb_line;
			ST_WETL: line_r_q <= fb_line;
			ST_WETR: out_l_q  <= wet_out;
			default: ;
		endcase
	end

	assign lwr.en   = finish;
	assign lwr.addr = wp_q;
	assign lwr.data = {line_r_q, line_l_q};

	spp_line_mem u_mem (
		.clk     (clk),
		.wr      (lwr),
		.rd_en   (in_acc),
		.rd_addr (wp_q + delay_q),
		.rd_data (mem_rdata)
	);

endmodule

FILE: rtl/core/spp_checker.sv
// spp_checker: port-level checks for stereo_ping_pong_delay, bound to the
// top level below. Depends only on the stream ports of the top level.
module spp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [31:0]                   m_axis_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	// busy right after a request
	a_busy_next: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready right after a request");

	// still busy late in the sequence
	a_busy_late: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> ##10 !s_axis_tready)
		else $error("request finished too early");

	// a new result only appears at the end of a busy period
	a_result_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without work");

endmodule

bind stereo_ping_pong_delay spp_checker u_spp_checker (.*);
